### sv/plc_pkg.sv
// ---------------------------------------------------------------------------
// Piecewise-linear calibrator package
// Sizes, codes, state encoding and the table command bundle shared by the
// calibrator modules.
// ---------------------------------------------------------------------------
`default_nettype none

package plc_pkg;

   // table geometry
   localparam int CHANNELS = 8;
   localparam int POINTS   = 16;
   localparam int DEPTH    = CHANNELS * POINTS;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int IDX_W    = $clog2(POINTS);
   localparam int WI_W     = $clog2(POINTS + 1);
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // channels covered by the calibrated mask register
   localparam int MASK_CHANNELS = 8;

   // coordinates and arithmetic widths
   localparam int          COORD_W     = 16;
   localparam logic [15:0] EMPTY_COORD = 16'hFFFF;
   localparam int          NUM_W       = 46;   // scaled dividend, even
   localparam int          DVS_W       = 17;   // twice the segment width

   // request modes
   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_ADD   = 2'd1;
   localparam logic [1:0] MODE_EVAL  = 2'd2;
   localparam logic [1:0] MODE_NOP   = 2'd3;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_CHANNEL = 3'd1,
      ST_UNCAL       = 3'd2,
      ST_FEW_POINTS  = 3'd3,
      ST_ZERO_WIDTH  = 3'd4,
      ST_TABLE_FULL  = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_CALC,
      S_MUL,
      S_SUM,
      S_SCALE,
      S_DIV_GO,
      S_DIV_WAIT,
      S_SAT,
      S_DONE
   } state_type;

   // one cycle's worth of table accesses
   typedef struct packed {
      logic               wr_en;
      logic [CH_W-1:0]    wr_chan;
      logic [IDX_W-1:0]   wr_idx;
      logic [31:0]        wr_data;
      logic               clr_en;
      logic [CH_W-1:0]    clr_chan;
      logic               rd_en;
      logic [CH_W-1:0]    rd_chan;
      logic [IDX_W-1:0]   rd_idx;
   } tbl_cmd_type;

endpackage

`default_nettype wire

### sv/piecewise_linear_calibrator_top.sv
// ---------------------------------------------------------------------------
// Piecewise-linear calibrator, top level
// Per-channel point tables with clear, append and evaluate requests.
//
//   channel  direction  handshake        payload
//   req      in         valid / stall    mode, channel, sample, point_x, point_y
//   rsp      out        valid / stall    value (signed Q23.8), status
//   csr      in         valid / ready    calibrated_mask
//
// Clear and append go straight to the result. Evaluation walks the
// channel's points, one memory read a cycle, then multiply, sum and scale
// and a two-bit-a-cycle divider (NUM_W/2 = 23 steps), then saturate and
// hand over. One request is in flight at a time.
// Reset is synchronous; table entries are marked empty by per-entry valid
// bits, so no clearing pass is needed. A stalled result holds in the
// output register while the next request may already be accepted.
// ---------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_calibrator_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [1:0]   req_mode,
   input  wire logic [3:0]   req_channel,
   input  wire logic [15:0]  req_sample,
   input  wire logic [15:0]  req_point_x,
   input  wire logic [15:0]  req_point_y,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic [2:0]        rsp_status,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_calibrated_mask
);

   localparam int CH_W  = plc_pkg::CH_W;
   localparam int IDX_W = plc_pkg::IDX_W;
   localparam int WI_W  = plc_pkg::WI_W;
   localparam int NUM_W = plc_pkg::NUM_W;
   localparam int DVS_W = plc_pkg::DVS_W;
   localparam logic [NUM_W-1:0] SAT_POS = NUM_W'(64'h7FFF_FFFF);
   localparam logic [NUM_W-1:0] SAT_NEG = NUM_W'(64'h8000_0000);

   plc_pkg::state_type   state_ff, state_in;
   plc_pkg::tbl_cmd_type tbl_cmd;
   plc_pkg::status_type  res_status_ff;
   plc_pkg::status_type  rsp_status_ff;

   logic [7:0]           mask_ff;
   logic [WI_W-1:0]      wi_ff [plc_pkg::CHANNELS];
   logic [CH_W-1:0]      ch_ff;
   logic [15:0]          sample_ff;
   logic [31:0]          res_value_ff;
   logic                 rsp_valid_ff;
   logic [31:0]          rsp_value_ff;

   // scan registers
   logic [WI_W-1:0]      iss_ff;
   logic                 chk_vld_ff;
   logic [IDX_W-1:0]     chk_idx_ff;
   logic [WI_W-1:0]      cnt_ff;
   logic [15:0]          x0_ff, y0_ff, ax_ff, ay_ff, bx_ff, by_ff;
   logic [15:0]          rd_x, rd_y;
   logic                 scan_end;

   // arithmetic registers
   logic signed [16:0]   op_a1_ff, op_b1_ff, op_a2_ff, den_ff;
   logic signed [17:0]   op_b2_ff;
   logic signed [33:0]   p1_ff;
   logic signed [34:0]   p2_ff;
   logic signed [35:0]   num_ff, num_adj;
   logic [15:0]          dmag_ff;
   logic [NUM_W-1:0]     a_ff;
   logic [NUM_W-1:0]     mag;
   logic [DVS_W-1:0]     dvs;
   logic                 div_start, div_done;
   logic [NUM_W-1:0]     quotient;

   logic accept, chan_ok, uncal, full, load_rsp;
   logic [CH_W-1:0] req_ch;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != plc_pkg::S_IDLE);
   assign csr_ready = 1'b1;
   assign req_ch    = req_channel[CH_W-1:0];
   assign chan_ok   = ({1'b0, req_channel} < 5'(plc_pkg::CHANNELS));
   assign uncal     = (req_channel >= 4'(plc_pkg::MASK_CHANNELS))
                   || !mask_ff[req_channel[2:0]];
   assign full      = (wi_ff[req_ch] >= WI_W'(plc_pkg::POINTS));
   assign load_rsp  = (state_ff == plc_pkg::S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // hold the calibrated mask
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         mask_ff <= csr_calibrated_mask;
      end
   end

   // table accesses: write and clear on accept, reads while scanning
   always_comb begin
      tbl_cmd          = '0;
      tbl_cmd.wr_chan  = req_ch;
      tbl_cmd.wr_idx   = wi_ff[req_ch][IDX_W-1:0];
      tbl_cmd.wr_data  = {req_point_y, req_point_x};
      tbl_cmd.clr_chan = req_ch;
      tbl_cmd.rd_chan  = ch_ff;
      tbl_cmd.rd_idx   = iss_ff[IDX_W-1:0];
      if (accept && chan_ok) begin
         tbl_cmd.wr_en  = (req_mode == plc_pkg::MODE_ADD) && !full;
         tbl_cmd.clr_en = (req_mode == plc_pkg::MODE_CLEAR);
      end
      tbl_cmd.rd_en = (state_ff == plc_pkg::S_SCAN) && (iss_ff < WI_W'(plc_pkg::POINTS));
   end

   plc_table u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (tbl_cmd),
      .rd_x  (rd_x),
      .rd_y  (rd_y)
   );

   // advance write indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < plc_pkg::CHANNELS; c++) begin
            wi_ff[c] <= '0;
         end
      end else if (tbl_cmd.clr_en) begin
         wi_ff[req_ch] <= '0;
      end else if (tbl_cmd.wr_en) begin
         wi_ff[req_ch] <= wi_ff[req_ch] + WI_W'(1);
      end
   end

   // scan ends on an empty point, on a segment above the sample, or at the end
   assign scan_end = chk_vld_ff
                  && ((rd_x == plc_pkg::EMPTY_COORD)
                  || ((chk_idx_ff != '0) && (rd_x > sample_ff))
                  || (chk_idx_ff == IDX_W'(plc_pkg::POINTS - 1)));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         plc_pkg::S_IDLE: begin
            if (accept) begin
               if (chan_ok && req_mode == plc_pkg::MODE_EVAL && !uncal) begin
                  state_in = plc_pkg::S_SCAN;
               end else begin
                  state_in = plc_pkg::S_DONE;
               end
            end
         end
         plc_pkg::S_SCAN: begin
            if (scan_end) begin
               state_in = plc_pkg::S_CALC;
            end
         end
         plc_pkg::S_CALC: begin
            if (cnt_ff < WI_W'(2)) begin
               state_in = plc_pkg::S_DONE;
            end else if (sample_ff < x0_ff || ax_ff != bx_ff) begin
               state_in = plc_pkg::S_MUL;
            end else begin
               state_in = plc_pkg::S_DONE;
            end
         end
         plc_pkg::S_MUL:      state_in = plc_pkg::S_SUM;
         plc_pkg::S_SUM:      state_in = plc_pkg::S_SCALE;
         plc_pkg::S_SCALE:    state_in = plc_pkg::S_DIV_GO;
         plc_pkg::S_DIV_GO:   state_in = plc_pkg::S_DIV_WAIT;
         plc_pkg::S_DIV_WAIT: begin
            if (div_done) begin
               state_in = plc_pkg::S_SAT;
            end
         end
         plc_pkg::S_SAT:      state_in = plc_pkg::S_DONE;
         plc_pkg::S_DONE: begin
            if (load_rsp) begin
               state_in = plc_pkg::S_IDLE;
            end
         end
         default:             state_in = plc_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // scan control
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_vld_ff <= 1'b0;
      end else begin
         chk_vld_ff <= tbl_cmd.rd_en;
      end
   end

   // request datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         plc_pkg::S_IDLE: begin
            ch_ff        <= req_ch;
            sample_ff    <= req_sample;
            iss_ff       <= '0;
            cnt_ff       <= '0;
            res_value_ff <= '0;
            // the spare mode answers ok on any channel
            if (req_mode == plc_pkg::MODE_NOP) begin
               res_status_ff <= plc_pkg::ST_OK;
            end else if (!chan_ok) begin
               res_status_ff <= plc_pkg::ST_BAD_CHANNEL;
            end else begin
               case (req_mode)
                  plc_pkg::MODE_ADD:  res_status_ff <= full ? plc_pkg::ST_TABLE_FULL
                                                            : plc_pkg::ST_OK;
                  plc_pkg::MODE_EVAL: res_status_ff <= uncal ? plc_pkg::ST_UNCAL
                                                             : plc_pkg::ST_OK;
                  default:            res_status_ff <= plc_pkg::ST_OK;
               endcase
            end
         end
         plc_pkg::S_SCAN: begin
            if (tbl_cmd.rd_en) begin
               iss_ff <= iss_ff + WI_W'(1);
            end
            chk_idx_ff <= iss_ff[IDX_W-1:0];
            if (chk_vld_ff && rd_x != plc_pkg::EMPTY_COORD) begin
               cnt_ff <= cnt_ff + WI_W'(1);
               if (chk_idx_ff == '0) begin
                  x0_ff <= rd_x;
                  y0_ff <= rd_y;
               end
               ax_ff <= bx_ff;
               ay_ff <= by_ff;
               bx_ff <= rd_x;
               by_ff <= rd_y;
            end
         end
         plc_pkg::S_CALC: begin
            // pick the line: proportional below the first point, else segment; flag too few points or zero width
            if (cnt_ff < WI_W'(2)) begin
               res_status_ff <= plc_pkg::ST_FEW_POINTS;
            end else if (sample_ff < x0_ff) begin
               op_a1_ff <= $signed({1'b0, y0_ff});
               op_b1_ff <= $signed({1'b0, sample_ff});
               op_a2_ff <= '0;
               op_b2_ff <= '0;
               den_ff   <= $signed({1'b0, x0_ff});
            end else if (ax_ff == bx_ff) begin
               res_status_ff <= plc_pkg::ST_ZERO_WIDTH;
            end else begin
               op_a1_ff <= $signed({1'b0, ay_ff});
               op_b1_ff <= $signed({1'b0, bx_ff}) - $signed({1'b0, ax_ff});
               op_a2_ff <= $signed({1'b0, by_ff}) - $signed({1'b0, ay_ff});
               op_b2_ff <= $signed({2'b0, sample_ff}) - $signed({2'b0, ax_ff});
               den_ff   <= $signed({1'b0, bx_ff}) - $signed({1'b0, ax_ff});
            end
         end
         plc_pkg::S_MUL: begin
            p1_ff <= op_a1_ff * op_b1_ff;
            p2_ff <= op_a2_ff * op_b2_ff;
         end
         plc_pkg::S_SUM: begin
            num_ff  <= 36'(p1_ff) + 36'(p2_ff);
            dmag_ff <= den_ff[16] ? 16'(-den_ff) : den_ff[15:0];
         end
         plc_pkg::S_SCALE: begin
            // numerator * 512 plus the positive denominator
            a_ff <= (NUM_W'(num_adj) <<< 9) + NUM_W'(dmag_ff);
         end
         plc_pkg::S_SAT: begin
            if (a_ff[NUM_W-1]) begin
               res_value_ff <= (quotient > SAT_NEG) ? 32'h8000_0000 : (32'd0 - quotient[31:0]);
            end else begin
               res_value_ff <= (quotient > SAT_POS) ? 32'h7FFF_FFFF : quotient[31:0];
            end
         end
         default: begin
         end
      endcase
   end

   // flip the numerator when the denominator is negative
   assign num_adj = den_ff[16] ? -num_ff : num_ff;

   // floor division of a signed dividend by a positive divisor
   assign dvs       = {dmag_ff, 1'b0};
   assign mag       = a_ff[NUM_W-1] ? ((NUM_W'(dvs) - NUM_W'(1)) - a_ff) : a_ff;
   assign div_start = (state_ff == plc_pkg::S_DIV_GO);

   plc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag),
      .divisor  (dvs),
      .done     (div_done),
      .quotient (quotient)
   );

   // output register: load when free or being taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_value_ff  <= (res_status_ff == plc_pkg::ST_OK) ? res_value_ff : 32'd0;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = $signed(rsp_value_ff);
   assign rsp_status = rsp_status_ff;

`ifndef SYNTHESIS
   // an error result carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != plc_pkg::ST_OK) |-> (rsp_value == 32'sd0))
      else $error("error result with nonzero value");

   // an accepted request blocks the next one
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request accepted while busy");

   // the divider only finishes while it is being waited on
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == plc_pkg::S_DIV_WAIT))
      else $error("divider finished outside wait state");

   // a table read never overlaps a write or a clear
   a_rd_scan: assert property (@(posedge clock) disable iff (reset)
      tbl_cmd.rd_en |-> !tbl_cmd.wr_en && !tbl_cmd.clr_en)
      else $error("table read overlaps a write");
`endif

endmodule

`default_nettype wire

### sv/plc_table.sv
// ---------------------------------------------------------------------------
// Calibration point table
// Synchronous point memory with one valid bit per entry. An entry that is
// not valid reads as an empty point (all ones). Reads are registered.
// ---------------------------------------------------------------------------
`default_nettype none

module plc_table (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire plc_pkg::tbl_cmd_type  cmd,
   output logic [15:0]                rd_x,
   output logic [15:0]                rd_y
);

   logic [31:0] mem [plc_pkg::DEPTH];
   logic [plc_pkg::CHANNELS-1:0][plc_pkg::POINTS-1:0] valid_ff;
   logic [31:0] rd_data_ff;
   logic        rd_valid_ff;
   logic [plc_pkg::ADDR_W-1:0] wr_addr;
   logic [plc_pkg::ADDR_W-1:0] rd_addr;

   // flatten channel and point index
   assign wr_addr = plc_pkg::ADDR_W'(cmd.wr_chan) * plc_pkg::ADDR_W'(plc_pkg::POINTS)
                  + plc_pkg::ADDR_W'(cmd.wr_idx);
   assign rd_addr = plc_pkg::ADDR_W'(cmd.rd_chan) * plc_pkg::ADDR_W'(plc_pkg::POINTS)
                  + plc_pkg::ADDR_W'(cmd.rd_idx);

   // write and read the point store; writes and reads never share a request
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // track written entries; clear a whole channel row at once
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_en) begin
            valid_ff[cmd.clr_chan] <= '0;
         end
         if (cmd.wr_en) begin
            valid_ff[cmd.wr_chan][cmd.wr_idx] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[cmd.rd_chan][cmd.rd_idx];
         end
      end
   end

   assign rd_x = rd_valid_ff ? rd_data_ff[15:0]  : plc_pkg::EMPTY_COORD;
   assign rd_y = rd_valid_ff ? rd_data_ff[31:16] : plc_pkg::EMPTY_COORD;

endmodule

`default_nettype wire

### sv/plc_div.sv
// ---------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division, two quotient bits per cycle. Pulses done for one
// cycle when the quotient is ready.
// ---------------------------------------------------------------------------
`default_nettype none

module plc_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [plc_pkg::NUM_W-1:0]   dividend,
   input  wire logic [plc_pkg::DVS_W-1:0]   divisor,
   output logic                             done,
   output logic [plc_pkg::NUM_W-1:0]        quotient
);

   localparam int STEPS = plc_pkg::NUM_W / 2;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [plc_pkg::NUM_W-1:0] quo_ff, quo_in;
   logic [plc_pkg::DVS_W-1:0] rem_ff, rem_in;
   logic [plc_pkg::DVS_W-1:0] dvs_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic                      busy_ff;
   logic                      done_ff;
   logic [plc_pkg::DVS_W:0]   r1, r1n, r2, r2n;
   logic                      ge1, ge2;

   // two restoring steps
   always_comb begin
      r1     = {rem_ff, quo_ff[plc_pkg::NUM_W-1]};
      ge1    = (r1 >= {1'b0, dvs_ff});
      r1n    = ge1 ? (r1 - {1'b0, dvs_ff}) : r1;
      r2     = {r1n[plc_pkg::DVS_W-1:0], quo_ff[plc_pkg::NUM_W-2]};
      ge2    = (r2 >= {1'b0, dvs_ff});
      r2n    = ge2 ? (r2 - {1'b0, dvs_ff}) : r2;
      rem_in = r2n[plc_pkg::DVS_W-1:0];
      quo_in = {quo_ff[plc_pkg::NUM_W-3:0], ge1, ge2};
   end

   // datapath: load on start, shift while busy
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   // control: count steps and flag the end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### bench/piecewise_linear_calibrator_top_tb.sv
// ---------------------------------------------------------------------------
// Piecewise-linear calibrator testbench
// Drives clear, append, evaluate and spare-mode requests with random gaps and stalls,
// predicts every response from a local copy of the point tables and the
// calibrated mask, and compares value and status in order.
// ---------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_calibrator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  channel;
      logic [15:0] sample;
      logic [15:0] point_x;
      logic [15:0] point_y;
   } cal_req_type;

   typedef struct packed {
      logic signed [31:0]  value;
      plc_pkg::status_type status;
   } cal_rsp_type;

   localparam int TIMEOUT_CYCLES = 400000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_mode = '0;
   logic [3:0]        req_channel = '0;
   logic [15:0]       req_sample = '0;
   logic [15:0]       req_point_x = '0;
   logic [15:0]       req_point_y = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic signed [31:0] rsp_value;
   logic [2:0]        rsp_status;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [7:0]        csr_calibrated_mask = '0;

   // predictor state
   logic [31:0] cal_points [plc_pkg::CHANNELS*plc_pkg::POINTS];
   int          append_idx [plc_pkg::CHANNELS];
   logic [7:0]  cal_mask;

   cal_req_type pending_reqs [$];
   cal_rsp_type expected_rsps [$];
   int          mismatches = 0;
   int          cycle_count = 0;
   int          hold_off = 0;
   bit          drive_on = 1'b0;
   int          req_gap = 0;
   int          rsp_gap = 0;

   piecewise_linear_calibrator_top i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   // round(num*256/den), ties up, saturated to 32 bits
   function automatic logic signed [31:0] scale_q8(input longint num, input longint den);
      longint n, d, q, a;
      n = num; d = den;
      if (d < 0) begin
         d = -d; n = -n;
      end
      a = n * 512 + d;
      q = a / (d * 2);
      if ((a % (d * 2)) != 0 && a < 0) q--;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
   endfunction

   function automatic cal_rsp_type calibrate(input cal_req_type r);
      cal_rsp_type res;
      int base, count, hi;
      longint s, x1, y1, x2, y2;
      res.value = '0;
      res.status = plc_pkg::ST_OK;
      s = r.sample;
      if (r.mode == plc_pkg::MODE_NOP) return res;
      if (r.channel >= plc_pkg::CHANNELS) begin
         res.status = plc_pkg::ST_BAD_CHANNEL;
         return res;
      end
      base = r.channel * plc_pkg::POINTS;
      case (r.mode)
         plc_pkg::MODE_CLEAR: begin
            for (int i = 0; i < plc_pkg::POINTS; i++) cal_points[base+i] = '1;
            append_idx[r.channel] = 0;
            return res;
         end
         plc_pkg::MODE_ADD: begin
            if (append_idx[r.channel] >= plc_pkg::POINTS) begin
               res.status = plc_pkg::ST_TABLE_FULL;
               return res;
            end
            cal_points[base+append_idx[r.channel]] = {r.point_y, r.point_x};
            append_idx[r.channel]++;
            return res;
         end
         default: ;
      endcase
      if (r.channel >= plc_pkg::MASK_CHANNELS || !cal_mask[r.channel]) begin
         res.status = plc_pkg::ST_UNCAL;
         return res;
      end
      count = plc_pkg::POINTS;
      for (int i = 0; i < plc_pkg::POINTS; i++)
         if (cal_points[base+i][15:0] == plc_pkg::EMPTY_COORD) begin
            count = i;
            break;
         end
      if (count < 2) begin
         res.status = plc_pkg::ST_FEW_POINTS;
         return res;
      end
      if (s < cal_points[base][15:0]) begin
         res.value = scale_q8(longint'(cal_points[base][31:16]) * s,
                              longint'(cal_points[base][15:0]));
         return res;
      end
      hi = 0;
      for (int i = 0; i < count; i++)
         if (cal_points[base+i][15:0] > s) begin
            hi = i;
            break;
         end
      if (hi == 0) hi = count - 1;
      x1 = cal_points[base+hi-1][15:0];
      y1 = cal_points[base+hi-1][31:16];
      x2 = cal_points[base+hi][15:0];
      y2 = cal_points[base+hi][31:16];
      if (x2 == x1) begin
         res.status = plc_pkg::ST_ZERO_WIDTH;
         return res;
      end
      res.value = scale_q8(y1 * (x2 - x1) + (y2 - y1) * (s - x1), x2 - x1);
      return res;
   endfunction

   function automatic cal_req_type make_req(input logic [1:0] m, input int ch,
                                            input int smp, input int px, input int py);
      cal_req_type r;
      r.mode = m;
      r.channel = 4'(ch);
      r.sample = 16'(smp);
      r.point_x = 16'(px);
      r.point_y = 16'(py);
      return r;
   endfunction

   // build a table on a channel then evaluate a handful of samples
   task automatic queue_table(input int ch, input int npts);
      int x;
      x = $urandom_range(0, 2000);
      pending_reqs.push_back(make_req(plc_pkg::MODE_CLEAR, ch, 0, 0, 0));
      for (int i = 0; i < npts; i++) begin
         if ($urandom_range(0, 15) == 0) x = $urandom_range(0, 65534);
         else x = (x + $urandom_range(0, 6000)) % 65535;
         pending_reqs.push_back(make_req(plc_pkg::MODE_ADD, ch, 0, x,
                                         $urandom_range(0, 65534)));
      end
      for (int i = $urandom_range(2, 8); i > 0; i--)
         pending_reqs.push_back(make_req(plc_pkg::MODE_EVAL, ch, $urandom, 0, 0));
   endtask

   task automatic write_mask(input logic [7:0] m);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_calibrated_mask <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cal_mask = m;
   endtask

   // release the driver and wait until every request has been answered
   task automatic run_phase();
      drive_on = 1'b1;
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
      drive_on = 1'b0;
      repeat (60) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(calibrate({req_mode, req_channel, req_sample,
                                               req_point_x, req_point_y}));
            req_gap = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) req_gap = 0;
         end
         if (req_valid && req_stall) begin
            // hold the stalled request
         end else if (req_gap > 0 || !drive_on || pending_reqs.size() == 0) begin
            req_valid <= 1'b0;
            if (req_gap > 0) req_gap--;
         end else begin
            cal_req_type r;
            r = pending_reqs.pop_front();
            req_valid <= 1'b1;
            {req_mode, req_channel, req_sample, req_point_x, req_point_y} <= r;
            req_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
            if (req_gap > 0) req_gap--;
         end
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("response with none expected");
            end else begin
               cal_rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_value !== e.value)
                  report_mismatch($sformatf("value %0d, expected %0d", rsp_value, e.value));
               if (rsp_status !== e.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, e.status));
            end
            rsp_gap = $urandom_range(0, 9);
            if ($urandom_range(0, 2) == 0) rsp_gap = 0;
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_stall <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      for (int i = 0; i < plc_pkg::CHANNELS*plc_pkg::POINTS; i++) cal_points[i] = '1;
      for (int i = 0; i < plc_pkg::CHANNELS; i++) append_idx[i] = 0;
      cal_mask = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: uncalibrated, bad channel, spare mode, few points
      pending_reqs.push_back(make_req(plc_pkg::MODE_EVAL, 0, 100, 0, 0));
      pending_reqs.push_back(make_req(plc_pkg::MODE_EVAL, 12, 100, 0, 0));
      pending_reqs.push_back(make_req(plc_pkg::MODE_NOP, 15, 16'hFFFF, 16'hFFFE, 16'hFFFE));
      pending_reqs.push_back(make_req(plc_pkg::MODE_ADD, 9, 0, 5, 5));
      pending_reqs.push_back(make_req(plc_pkg::MODE_CLEAR, 8, 0, 0, 0));
      run_phase();
      write_mask(8'hFF);
      pending_reqs.push_back(make_req(plc_pkg::MODE_EVAL, 0, 100, 0, 0));
      pending_reqs.push_back(make_req(plc_pkg::MODE_EVAL, 10, 100, 0, 0));
      pending_reqs.push_back(make_req(plc_pkg::MODE_ADD, 0, 0, 1000, 65534));
      pending_reqs.push_back(make_req(plc_pkg::MODE_EVAL, 0, 100, 0, 0));
      pending_reqs.push_back(make_req(plc_pkg::MODE_ADD, 0, 0, 1000, 0));
      pending_reqs.push_back(make_req(plc_pkg::MODE_EVAL, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(plc_pkg::MODE_EVAL, 0, 1000, 0, 0));
      pending_reqs.push_back(make_req(plc_pkg::MODE_EVAL, 0, 65535, 0, 0));
      // extremes and descending x
      pending_reqs.push_back(make_req(plc_pkg::MODE_CLEAR, 1, 0, 0, 0));
      pending_reqs.push_back(make_req(plc_pkg::MODE_ADD, 1, 0, 1, 65534));
      pending_reqs.push_back(make_req(plc_pkg::MODE_ADD, 1, 0, 0, 0));
      pending_reqs.push_back(make_req(plc_pkg::MODE_EVAL, 1, 65535, 0, 0));
      pending_reqs.push_back(make_req(plc_pkg::MODE_EVAL, 1, 0, 0, 0));
      pending_reqs.push_back(make_req(plc_pkg::MODE_ADD, 1, 0, 16'hFFFF, 16'hFFFF));
      pending_reqs.push_back(make_req(plc_pkg::MODE_EVAL, 1, 3, 0, 0));
      // table full on channel 7
      for (int i = 0; i <= plc_pkg::POINTS; i++)
         pending_reqs.push_back(make_req(plc_pkg::MODE_ADD, 7, 0, i*4000,
                                         65534 - i*4000));
      pending_reqs.push_back(make_req(plc_pkg::MODE_EVAL, 7, 65535, 0, 0));
      run_phase();

      // long receiver hold-off while requests keep coming
      queue_table(2, 4);
      queue_table(3, 5);
      hold_off = 300;
      run_phase();

      // random phases across mask settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_mask(8'h00);
            5: write_mask(8'hFF);
            default: write_mask(8'($urandom_range(0, 255)));
         endcase
         while (pending_reqs.size() < 150) begin
            if ($urandom_range(0, 9) < 8) begin
               queue_table($urandom_range(0, plc_pkg::CHANNELS-1),
                           $urandom_range(0, plc_pkg::POINTS));
            end else begin
               pending_reqs.push_back(make_req(2'($urandom_range(0, 3)),
                                               $urandom_range(0, 15),
                                               $urandom, $urandom, $urandom));
            end
         end
         run_phase();
      end

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

### piecewise_linear_calibrator_top.f
sv/plc_pkg.sv
sv/plc_table.sv
sv/plc_div.sv
sv/piecewise_linear_calibrator_top.sv
bench/piecewise_linear_calibrator_top_tb.sv
